### sv/bptc_pkg.sv
`timescale 1ns / 1ps
// bptc_pkg: word types, register indexes and constants for the barometric
// pressure / temperature compensation block. no dependencies.
package bptc_pkg;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_word;

    typedef struct packed {
        logic signed [18:0] temp_centi;
        logic        [19:0] pressure_pa;
    } t_out_word;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_SLOPE  = 3'd5;

    localparam int unsigned NUM_STAGES = 6;

    localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
    localparam logic        [19:0] PRES_MAX  = 20'hFFFFF;

endpackage

### sv/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// baro_pressure_temp_compensation: six-stage pipelined first-order
// compensation of raw pressure and temperature words. depends on bptc_pkg.
//
// throughput: one word per cycle while the output is not stalled; the 24 x 36
//   pressure product is split into two partial products in their own stage
// backpressure: a stage takes a word when it is empty or its word moves on,
//   so bubbles are squeezed out while the output word waits
// reset: synchronous active low, clears all stage valid bits and the six
//   calibration registers to zero
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // calibration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // raw sample word in
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_data,

    // compensated word out
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_data
);

    // calibration registers
    logic [15:0] r_sens_coef;
    logic [15:0] r_offset_coef;
    logic [15:0] r_sens_temp_coef;
    logic [15:0] r_offset_temp_coef;
    logic [15:0] r_ref_temp_coef;
    logic [15:0] r_temp_slope_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_coef        <= '0;
            r_offset_coef      <= '0;
            r_sens_temp_coef   <= '0;
            r_offset_temp_coef <= '0;
            r_ref_temp_coef    <= '0;
            r_temp_slope_coef  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SENS:        r_sens_coef        <= i_cfg_wdata;
                REG_OFFSET:      r_offset_coef      <= i_cfg_wdata;
                REG_SENS_TEMP:   r_sens_temp_coef   <= i_cfg_wdata;
                REG_OFFSET_TEMP: r_offset_temp_coef <= i_cfg_wdata;
                REG_REF_TEMP:    r_ref_temp_coef    <= i_cfg_wdata;
                REG_TEMP_SLOPE:  r_temp_slope_coef  <= i_cfg_wdata;
                default: ;       // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid bits and per-stage load enables
    // r_vld[k] belongs to stage k+1; the last one is the output register
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // stage 1: dT = raw_temperature - ref_temp * 256
    // ------------------------------------------------------------------
    logic signed [24:0] n_s1_dt;
    logic signed [24:0] r_s1_dt;
    logic        [23:0] r_s1_d1;

    assign n_s1_dt = $signed({1'b0, i_data.raw_temperature})
                   - $signed({1'b0, r_ref_temp_coef, 8'd0});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= i_data.raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: the three dT products, 25 x 17 signed each
    // ------------------------------------------------------------------
    logic signed [41:0] n_s2_pt;
    logic signed [41:0] n_s2_po;
    logic signed [41:0] n_s2_ps;
    logic signed [41:0] r_s2_pt;
    logic signed [41:0] r_s2_po;
    logic signed [41:0] r_s2_ps;
    logic        [23:0] r_s2_d1;

    assign n_s2_pt = r_s1_dt * $signed({1'b0, r_temp_slope_coef});
    assign n_s2_po = r_s1_dt * $signed({1'b0, r_offset_temp_coef});
    assign n_s2_ps = r_s1_dt * $signed({1'b0, r_sens_temp_coef});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_pt <= n_s2_pt;
            r_s2_po <= n_s2_po;
            r_s2_ps <= n_s2_ps;
            r_s2_d1 <= r_s1_d1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: truncating shifts, TEMP, OFF and SENS
    // a negative value gets 2^k-1 added before the arithmetic shift so the
    // quotient rounds toward zero
    // ------------------------------------------------------------------
    logic signed [41:0] w_pt_bias;
    logic signed [41:0] w_po_bias;
    logic signed [41:0] w_ps_bias;
    logic signed [18:0] w_temp_q;
    logic signed [35:0] w_off_q;
    logic signed [34:0] w_sens_q;
    logic signed [18:0] n_s3_temp;
    logic signed [36:0] n_s3_off;
    logic signed [35:0] n_s3_sens;
    logic signed [18:0] r_s3_temp;
    logic signed [36:0] r_s3_off;
    logic signed [35:0] r_s3_sens;
    logic        [23:0] r_s3_d1;

    assign w_pt_bias = r_s2_pt + (r_s2_pt[41] ? 42'sd8388607 : 42'sd0);
    assign w_po_bias = r_s2_po + (r_s2_po[41] ? 42'sd63 : 42'sd0);
    assign w_ps_bias = r_s2_ps + (r_s2_ps[41] ? 42'sd127 : 42'sd0);

    assign w_temp_q = w_pt_bias[41:23];
    assign w_off_q  = w_po_bias[41:6];
    assign w_sens_q = w_ps_bias[41:7];

    // temperature always fits its 19-bit field
    assign n_s3_temp = w_temp_q + TEMP_BASE;
    assign n_s3_off  = $signed({4'd0, r_offset_coef, 17'd0}) + {w_off_q[35], w_off_q};
    assign n_s3_sens = $signed({4'd0, r_sens_coef, 16'd0}) + {w_sens_q[34], w_sens_q};

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_temp <= n_s3_temp;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_d1   <= r_s2_d1;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: D1 * SENS as two partial products
    // low 18 bits of SENS unsigned, high 18 bits signed
    // ------------------------------------------------------------------
    logic signed [43:0] n_s4_pl;
    logic signed [42:0] n_s4_ph;
    logic signed [43:0] r_s4_pl;
    logic signed [42:0] r_s4_ph;
    logic signed [18:0] r_s4_temp;
    logic signed [36:0] r_s4_off;

    assign n_s4_pl = $signed({1'b0, r_s3_d1}) * $signed({1'b0, r_s3_sens[17:0]});
    assign n_s4_ph = $signed({1'b0, r_s3_d1}) * $signed(r_s3_sens[35:18]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_pl   <= n_s4_pl;
            r_s4_ph   <= n_s4_ph;
            r_s4_temp <= r_s3_temp;
            r_s4_off  <= r_s3_off;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: recombine the product and divide by 2^21 toward zero
    // ------------------------------------------------------------------
    logic signed [60:0] w_prod;
    logic signed [60:0] w_prod_bias;
    logic signed [39:0] n_s5_q1;
    logic signed [39:0] r_s5_q1;
    logic signed [18:0] r_s5_temp;
    logic signed [36:0] r_s5_off;

    assign w_prod      = $signed({r_s4_ph, 18'd0}) + {{17{r_s4_pl[43]}}, r_s4_pl};
    assign w_prod_bias = w_prod + (w_prod[60] ? 61'sd2097151 : 61'sd0);
    assign n_s5_q1     = w_prod_bias[60:21];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_q1   <= n_s5_q1;
            r_s5_temp <= r_s4_temp;
            r_s5_off  <= r_s4_off;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: subtract OFF, divide by 2^15 toward zero, saturate
    // ------------------------------------------------------------------
    logic signed [40:0] w_diff;
    logic signed [40:0] w_diff_bias;
    logic signed [25:0] w_pres_q;
    logic        [19:0] w_pres_sat;
    t_out_word          n_out;
    t_out_word          r_out;

    assign w_diff      = {r_s5_q1[39], r_s5_q1} - {{4{r_s5_off[36]}}, r_s5_off};
    assign w_diff_bias = w_diff + (w_diff[40] ? 41'sd32767 : 41'sd0);
    assign w_pres_q    = w_diff_bias[40:15];

    always_comb begin
        if (w_pres_q[25]) begin
            w_pres_sat = '0;                  // below zero
        end else if (w_pres_q[24:20] != 5'd0) begin
            w_pres_sat = PRES_MAX;            // above range
        end else begin
            w_pres_sat = w_pres_q[19:0];
        end
        n_out.temp_centi  = r_s5_temp;
        n_out.pressure_pa = w_pres_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // input stalls only when the whole pipe is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (&r_vld)))
        else $error("input stalled while the pipe has room");

    // a word in stage three with stage four empty always moves into it
    a_no_stuck_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_vld[3]) |=> r_vld[3])
        else $error("word did not advance into an empty stage");

    // an accepted word reaches stage one in the next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word lost at pipe entry");

    // reset leaves no word at the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
